@@ hw/rtl/tpba_pkg.sv @@
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared types and constants of the thread page bump allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpba_pkg;

   localparam int THREADS = 128;
   localparam int TID_W   = $clog2(THREADS);

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_BIND    = 3'd1,
      OP_RELEASE = 3'd2,
      OP_CLAMP   = 3'd3,
      OP_COLLECT = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_PAGE    = 2'd0,
      ST_NEWPAGE = 2'd1,
      ST_NOSPACE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_BYTES = 2'd0,
      CSR_PAGE_BYTES = 2'd1,
      CSR_HEAP_BASE  = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE,
      S_RESERVE,
      S_COMMIT,
      S_MODIFY,
      S_SWEEP,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [6:0]  thread_id;
      logic [31:0] alloc_bytes;
      logic [31:0] new_used_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] address;
      logic [31:0] used_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] cursor;
      logic [31:0] end_off;
      logic [31:0] limit;
   } page_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic take;
      logic reserve;
      logic commit;
      logic modify;
      logic sweep;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic fast_ok;
      logic tid_ok;
      logic reserve_ok;
      logic sweep_last;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/tpba_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpba_ctrl
// Sequencer: steps each request through page take, chunk reserve, page
// sweep or bookkeeping update, then strobes the response.
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_ctrl
   import tpba_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [2:0] operation,
   input  wire stat_type   stat,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == S_IDLE || state_ff == S_RESPOND);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE, S_RESPOND: begin
            if (start) begin
               case (operation)
                  OP_ALLOC: state_in = S_TAKE;
                  OP_CLAMP: state_in = S_SWEEP;
                  default:  state_in = S_MODIFY;
               endcase
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TAKE: begin
            if (!stat.fast_ok && stat.tid_ok) begin
               state_in = S_RESERVE;
            end else begin
               state_in = S_RESPOND;
            end
         end
         S_RESERVE: begin
            state_in = stat.reserve_ok ? S_COMMIT : S_RESPOND;
         end
         S_COMMIT: state_in = S_RESPOND;
         S_MODIFY: state_in = S_RESPOND;
         S_SWEEP: begin
            state_in = stat.sweep_last ? S_RESPOND : S_SWEEP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      cmd.take    = (state_ff == S_TAKE);
      cmd.reserve = (state_ff == S_RESERVE);
      cmd.commit  = (state_ff == S_COMMIT);
      cmd.modify  = (state_ff == S_MODIFY);
      cmd.sweep   = (state_ff == S_SWEEP);
      busy        = !(state_ff == S_IDLE || state_ff == S_RESPOND);
      rsp_valid   = (state_ff == S_RESPOND);
   end

endmodule

`default_nettype wire

@@ hw/rtl/tpba_datapath.sv @@
// ----------------------------------------------------------------------------
// tpba_datapath
// Page table memory, per-thread valid and active bits, bump pointer,
// configuration registers and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_datapath
   import tpba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire req_type     req_payload,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata,
   output rsp_type          rsp_payload
);

   // configuration
   logic [31:0] heap_ff;
   logic [31:0] page_ff;
   logic [47:0] base_ff;

   // captured request
   logic [2:0]       op_ff;
   logic [TID_W-1:0] tid_ff;
   logic             tid_ok_ff;
   logic [31:0]      req_ff;
   logic [31:0]      used_in_ff;

   logic [31:0]      bump_ff;
   logic [31:0]      bump_in;
   logic [31:0]      chunk_ff;
   logic [31:0]      chunk_in;
   logic [1:0]       status_ff;
   logic [47:0]      addr_ff;
   logic [TID_W-1:0] idx_ff;

   logic [THREADS-1:0] active_ff;
   logic [THREADS-1:0] valid_ff;

   page_type         mem [THREADS];
   page_type         rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_en;
   logic [TID_W-1:0] rd_addr;
   logic             wr_en;
   logic [TID_W-1:0] wr_addr;
   page_type         wr_data;

   page_type    page;
   logic [31:0] left;
   logic [31:0] want;

   // never-written or invalidated entries read as an empty page
   assign page = rd_valid_ff ? rd_data_ff : '0;

   assign left = heap_ff - bump_ff;
   assign want = (page_ff > req_ff) ? page_ff : req_ff;
   assign chunk_in = (want > left) ? left : want;
   assign bump_in = bump_ff + chunk_ff;

   always_comb begin
      stat            = '0;
      stat.tid_ok     = tid_ok_ff;
      stat.fast_ok    = tid_ok_ff && (page.cursor <= page.end_off)
                        && (page.end_off <= page.limit)
                        && (req_ff <= page.end_off - page.cursor);
      stat.reserve_ok = (bump_ff < heap_ff) && (left >= req_ff);
      stat.sweep_last = (idx_ff == TID_W'(THREADS - 1));
   end

   // a clamp walk starts at entry zero
   assign rd_en   = cmd.capture || cmd.sweep;
   assign rd_addr = !cmd.capture ? idx_ff + TID_W'(1)
                  : (req_payload.operation == OP_CLAMP) ? '0
                  : req_payload.thread_id[TID_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tid_ff;
      wr_data = '0;
      if (cmd.take) begin
         wr_en           = stat.fast_ok;
         wr_data         = page;
         wr_data.cursor  = page.cursor + req_ff;
      end else if (cmd.commit) begin
         wr_en           = 1'b1;
         wr_data.cursor  = bump_ff + req_ff;
         wr_data.end_off = bump_in;
         wr_data.limit   = bump_in;
      end else if (cmd.sweep) begin
         // clamp: limit follows the cursor on active threads
         wr_en           = active_ff[idx_ff];
         wr_addr         = idx_ff;
         wr_data         = page;
         wr_data.limit   = page.cursor;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= '0;
         page_ff <= 32'd4096;
         base_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BYTES: heap_ff <= csr_wdata[31:0];
            CSR_PAGE_BYTES: page_ff <= csr_wdata[31:0];
            CSR_HEAP_BASE:  base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         bump_ff     <= '0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.commit) begin
            bump_ff <= bump_in;
         end
         if (cmd.modify) begin
            case (op_ff)
               OP_BIND: begin
                  if (tid_ok_ff) begin
                     active_ff[tid_ff] <= 1'b1;
                     valid_ff[tid_ff]  <= 1'b0;
                  end
               end
               OP_RELEASE: begin
                  if (tid_ok_ff) begin
                     active_ff[tid_ff] <= 1'b0;
                     valid_ff[tid_ff]  <= 1'b0;
                  end
               end
               OP_COLLECT: begin
                  bump_ff  <= used_in_ff;
                  valid_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_payload.operation;
         tid_ff     <= req_payload.thread_id[TID_W-1:0];
         tid_ok_ff  <= (32'(req_payload.thread_id) < THREADS);
         req_ff     <= req_payload.alloc_bytes;
         used_in_ff <= req_payload.new_used_bytes;
         status_ff  <= ST_PAGE;
         addr_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         if (cmd.take) begin
            if (stat.fast_ok) begin
               status_ff <= ST_PAGE;
               addr_ff   <= base_ff + 48'(page.cursor);
            end else begin
               status_ff <= ST_NOSPACE;
               addr_ff   <= '0;
            end
         end
         if (cmd.reserve) begin
            chunk_ff <= chunk_in;
         end
         if (cmd.commit) begin
            status_ff <= ST_NEWPAGE;
            addr_ff   <= base_ff + 48'(bump_ff);
         end
         if (cmd.sweep) begin
            idx_ff <= idx_ff + TID_W'(1);
         end
      end
   end

   assign rsp_payload.status     = status_ff;
   assign rsp_payload.address    = addr_ff;
   assign rsp_payload.used_bytes = bump_ff;

endmodule

`default_nettype wire

@@ hw/rtl/thread_page_bump_allocator.sv @@
// Sequence: an allocate served from the thread page passes take and respond, as
//   bind, release and collection pass modify and respond; a failed chunk
//   reservation passes take, reserve and respond; a new page adds commit.
// A request is accepted in the response cycle; busy holds off requests before it,
//   and clamp walks the page memory one entry a cycle. Reset clears state, valid
//   and active bits, bump pointer and configuration registers at once.
// ----------------------------------------------------------------------------
// thread_page_bump_allocator
// Bump pointer heap allocator with one page per thread.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_page_bump_allocator
   import tpba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   tpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_payload.operation),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tpba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ hw/rtl/tpba_checker.sv @@
// ----------------------------------------------------------------------------
// tpba_checker
// Port-level checks on request and response sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module tpba_checker
   import tpba_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_payload
);

   // every accepted request raises busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held two cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_PAGE || rsp_payload.status == ST_NEWPAGE
                     || rsp_payload.status == ST_NOSPACE))
      else $error("undefined status code");

   a_nospace_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_NOSPACE |-> rsp_payload.address == '0)
      else $error("no space response carries an address");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind thread_page_bump_allocator tpba_checker u_checker (.*);

`default_nettype wire
